// ===== sv/lmsd_pkg.sv =====
package lmsd_pkg;

	localparam int WORD_W   = 16;
	localparam int LED_W    = 8;
	localparam int SCHED_W  = 6;
	localparam int LEVELS   = 4;
	localparam int CMD_W    = 2;
	localparam int REG_W    = 2;
	localparam int PANEL_W  = 3;
	localparam int ROW_W    = 3;
	localparam int COLOR_W  = 2;

	localparam int S_TDATA_W = 32;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 16;
	localparam int M_TUSER_W = 5;

	localparam int DEF_PANELS         = 5;
	localparam int DEF_ROWS           = 8;
	localparam int DEF_LEDS_PER_ROW   = 8;
	localparam int DEF_COLORS         = 3;
	localparam int DEF_REFRESH_CYCLES = 6;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK       = 2'd0,
		CMD_WRITE      = 2'd1,
		CMD_SWAP_DEFER = 2'd2,
		CMD_SWAP_NOW   = 2'd3
	} cmd_t;

	typedef enum logic [REG_W-1:0] {
		REG_SCHED_L0 = 2'd0,
		REG_SCHED_L1 = 2'd1,
		REG_SCHED_L2 = 2'd2,
		REG_SCHED_L3 = 2'd3
	} reg_idx_t;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_SWEEP = 1'b1
	} state_t;

	typedef logic [SCHED_W-1:0] sched_t;

	localparam sched_t SCHED_RST_L0 = 6'h00;
	localparam sched_t SCHED_RST_L1 = 6'h20;
	localparam sched_t SCHED_RST_L2 = 6'h24;
	localparam sched_t SCHED_RST_L3 = 6'h3f;

endpackage

// ===== sv/lmsd_ram.sv =====
module lmsd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 240
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/led_matrix_scan_dimmer_unit.sv =====
// Double-buffered LED matrix scanner. Commands arrive on the slave stream:
// row writes into the shown or hidden frame buffer, deferred or immediate
// buffer swaps, and scan ticks. Each tick steps the row (and after the last
// row the refresh cycle, and a pending swap takes effect when that counter
// wraps) and then streams one chunk per panel and color, colors inner, with
// tlast on the final one. The frame memory has a single read port and gives
// one chunk word per cycle while the master side does not stall, and no
// command is accepted until a tick's chunks are all read. After reset the
// frame reads as level 0 through per-word valid flags, so no clearing pass
// is needed. Schedule registers are picked up when a tick is accepted.
module led_matrix_scan_dimmer_unit #(
	parameter int PANELS         = lmsd_pkg::DEF_PANELS,
	parameter int ROWS           = lmsd_pkg::DEF_ROWS,
	parameter int LEDS_PER_ROW   = lmsd_pkg::DEF_LEDS_PER_ROW,
	parameter int COLORS         = lmsd_pkg::DEF_COLORS,
	parameter int REFRESH_CYCLES = lmsd_pkg::DEF_REFRESH_CYCLES
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            s_tvalid,
	output logic                            s_tready,
	// target_hidden, panel_sel[2:0], row_sel[2:0], color_sel[1:0], level_word[15:0]
	input  logic [lmsd_pkg::S_TDATA_W-1:0]  s_tdata,
	// cmd[1:0]
	input  logic [lmsd_pkg::S_TUSER_W-1:0]  s_tuser,

	output logic                            m_tvalid,
	input  logic                            m_tready,
	// drive_row[2:0], led_bits[7:0]
	output logic [lmsd_pkg::M_TDATA_W-1:0]  m_tdata,
	// out_panel[2:0], out_color[1:0]
	output logic [lmsd_pkg::M_TUSER_W-1:0]  m_tuser,
	output logic                            m_tlast,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lmsd_pkg::REG_W-1:0]      cfg_index,
	input  logic [lmsd_pkg::SCHED_W-1:0]    cfg_data
);

	localparam int DEPTH  = 2 * PANELS * ROWS * COLORS;
	localparam int AW     = $clog2(DEPTH);
	localparam int P_W    = (PANELS > 1) ? $clog2(PANELS) : 1;
	localparam int C_W    = (COLORS > 1) ? $clog2(COLORS) : 1;
	localparam int R_W    = $clog2(ROWS);
	localparam int RC_W   = (REFRESH_CYCLES > 1) ? $clog2(REFRESH_CYCLES) : 1;
	localparam int NLED   = (LEDS_PER_ROW < lmsd_pkg::LED_W) ? LEDS_PER_ROW : lmsd_pkg::LED_W;

	// input fields
	lmsd_pkg::cmd_t                 in_cmd;
	logic                           in_hidden;
	logic [lmsd_pkg::PANEL_W-1:0]   in_panel;
	logic [lmsd_pkg::ROW_W-1:0]     in_row;
	logic [lmsd_pkg::COLOR_W-1:0]   in_color;
	logic [lmsd_pkg::WORD_W-1:0]    in_word;

	assign in_cmd    = lmsd_pkg::cmd_t'(s_tuser[1:0]);
	assign in_hidden = s_tdata[0];
	assign in_panel  = s_tdata[3:1];
	assign in_row    = s_tdata[6:4];
	assign in_color  = s_tdata[8:7];
	assign in_word   = s_tdata[24:9];

	lmsd_pkg::state_t state_q, state_nx;

	lmsd_pkg::sched_t sched_q [lmsd_pkg::LEVELS];
	logic [R_W-1:0]   row_q;
	logic [RC_W-1:0]  rc_q;
	logic             shown_q;
	logic             pend_q;
	logic [lmsd_pkg::LEVELS-1:0] lvl_on_q;
	logic [P_W-1:0]   p_q;
	logic [C_W-1:0]   c_q;
	logic [DEPTH-1:0] vld_q;

	logic             rd_vld_s1;
	logic             vbit_s1;
	logic [P_W-1:0]   p_s1;
	logic [C_W-1:0]   c_s1;

	logic [lmsd_pkg::LED_W-1:0]  led_q;
	logic [lmsd_pkg::ROW_W-1:0]  orow_q;
	logic [lmsd_pkg::PANEL_W-1:0] opanel_q;
	logic [lmsd_pkg::COLOR_W-1:0] ocolor_q;
	logic             olast_q;
	logic             ovld_q;

	logic             in_xfer;
	logic             tick;
	logic             wr_en;
	logic [AW-1:0]    waddr;
	logic             issue;
	logic             last_issue;
	logic [AW-1:0]    raddr;
	logic [lmsd_pkg::WORD_W-1:0] rdata;
	logic [lmsd_pkg::WORD_W-1:0] word_s1;
	logic             load;

	logic [R_W-1:0]   row_nx;
	logic [RC_W-1:0]  rc_nx;
	logic             shown_nx;
	logic             pend_nx;
	logic [lmsd_pkg::LEVELS-1:0] lvl_on_nx;
	logic [lmsd_pkg::LED_W-1:0]  led_nx;

	// handshake and control
	assign in_xfer    = s_tvalid && s_tready;
	assign tick       = in_xfer && (in_cmd == lmsd_pkg::CMD_TICK);
	assign load       = rd_vld_s1 && (!ovld_q || m_tready);
	assign last_issue = (int'(p_q) == PANELS - 1) && (int'(c_q) == COLORS - 1);
	assign cfg_ready  = 1'b1;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			lmsd_pkg::ST_IDLE: begin
				if (tick) begin
					state_nx = lmsd_pkg::ST_SWEEP;
				end
			end
			lmsd_pkg::ST_SWEEP: begin
				if (issue && last_issue) begin
					state_nx = lmsd_pkg::ST_IDLE;
				end
			end
			default: state_nx = lmsd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		issue    = 1'b0;
		case (state_q)
			lmsd_pkg::ST_IDLE:  s_tready = !rd_vld_s1;
			lmsd_pkg::ST_SWEEP: issue    = !rd_vld_s1 || load;
			default: begin
				s_tready = 1'b0;
				issue    = 1'b0;
			end
		endcase
	end

	// frame memory addressing
	assign wr_en = in_xfer && (in_cmd == lmsd_pkg::CMD_WRITE)
		&& (int'(in_panel) < PANELS) && (int'(in_row) < ROWS) && (int'(in_color) < COLORS);
	assign waddr = AW'((((int'(shown_q ^ in_hidden) * PANELS + int'(in_panel)) * ROWS
		+ int'(in_row)) * COLORS) + int'(in_color));
	assign raddr = AW'((((int'(shown_q) * PANELS + int'(p_q)) * ROWS
		+ int'(row_q)) * COLORS) + int'(c_q));

	lmsd_ram #(
		.WIDTH (lmsd_pkg::WORD_W),
		.DEPTH (DEPTH)
	) u_frame (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr),
		.wdata (in_word),
		.re    (issue),
		.raddr (raddr),
		.rdata (rdata)
	);

	// scan counters on a tick
	always_comb begin
		row_nx   = row_q + R_W'(1);
		rc_nx    = rc_q;
		shown_nx = shown_q;
		pend_nx  = pend_q;
		if (int'(row_q) == ROWS - 1) begin
			row_nx = '0;
			if (int'(rc_q) == REFRESH_CYCLES - 1) begin
				rc_nx = '0;
				if (pend_q) begin
					shown_nx = !shown_q;
					pend_nx  = 1'b0;
				end
			end else begin
				rc_nx = rc_q + RC_W'(1);
			end
		end
	end

	// per level on bit for the coming refresh cycle
	always_comb begin
		lvl_on_nx = '0;
		for (int l = 0; l < lmsd_pkg::LEVELS; l++) begin
			for (int j = 0; j < lmsd_pkg::SCHED_W; j++) begin
				if (int'(rc_nx) == j) begin
					lvl_on_nx[l] = sched_q[l][j];
				end
			end
		end
	end

	assign word_s1 = vbit_s1 ? rdata : '0;

	always_comb begin
		led_nx = '0;
		for (int k = 0; k < NLED; k++) begin
			led_nx[k] = lvl_on_q[word_s1[2*k +: 2]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lmsd_pkg::ST_IDLE;
			sched_q[0] <= lmsd_pkg::SCHED_RST_L0;
			sched_q[1] <= lmsd_pkg::SCHED_RST_L1;
			sched_q[2] <= lmsd_pkg::SCHED_RST_L2;
			sched_q[3] <= lmsd_pkg::SCHED_RST_L3;
			row_q     <= '0;
			rc_q      <= '0;
			shown_q   <= 1'b1;
			pend_q    <= 1'b0;
			lvl_on_q  <= '0;
			p_q       <= '0;
			c_q       <= '0;
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
			ovld_q    <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready) begin
				case (lmsd_pkg::reg_idx_t'(cfg_index))
					lmsd_pkg::REG_SCHED_L0: sched_q[0] <= cfg_data;
					lmsd_pkg::REG_SCHED_L1: sched_q[1] <= cfg_data;
					lmsd_pkg::REG_SCHED_L2: sched_q[2] <= cfg_data;
					lmsd_pkg::REG_SCHED_L3: sched_q[3] <= cfg_data;
					default: ;
				endcase
			end
			if (wr_en) begin
				vld_q[waddr] <= 1'b1;
			end
			if (in_xfer && (in_cmd == lmsd_pkg::CMD_SWAP_DEFER)) begin
				pend_q <= 1'b1;
			end
			if (in_xfer && (in_cmd == lmsd_pkg::CMD_SWAP_NOW)) begin
				shown_q <= !shown_q;
			end
			if (tick) begin
				row_q    <= row_nx;
				rc_q     <= rc_nx;
				shown_q  <= shown_nx;
				pend_q   <= pend_nx;
				lvl_on_q <= lvl_on_nx;
				p_q      <= '0;
				c_q      <= '0;
			end
			if (issue) begin
				if (int'(c_q) == COLORS - 1) begin
					c_q <= '0;
					p_q <= p_q + P_W'(1);
				end else begin
					c_q <= c_q + C_W'(1);
				end
				rd_vld_s1 <= 1'b1;
			end else if (load) begin
				rd_vld_s1 <= 1'b0;
			end
			if (load) begin
				ovld_q <= 1'b1;
			end else if (m_tready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	// chunk tags follow the read, result register follows the tags
	always_ff @(posedge clk) begin
		if (issue) begin
			vbit_s1 <= vld_q[raddr];
			p_s1    <= p_q;
			c_s1    <= c_q;
		end
		if (load) begin
			led_q    <= led_nx;
			orow_q   <= lmsd_pkg::ROW_W'(int'(row_q));
			opanel_q <= lmsd_pkg::PANEL_W'(int'(p_s1));
			ocolor_q <= lmsd_pkg::COLOR_W'(int'(c_s1));
			olast_q  <= (int'(p_s1) == PANELS - 1) && (int'(c_s1) == COLORS - 1);
		end
	end

	assign m_tvalid = ovld_q;
	assign m_tdata  = {5'b0, led_q, orow_q};
	assign m_tuser  = {ocolor_q, opanel_q};
	assign m_tlast  = olast_q;

endmodule

// ===== test/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PANELS      = lmsd_pkg::DEF_PANELS;
	localparam int ROWS        = lmsd_pkg::DEF_ROWS;
	localparam int LEDS        = lmsd_pkg::DEF_LEDS_PER_ROW;
	localparam int COLORS      = lmsd_pkg::DEF_COLORS;
	localparam int CYCLES      = lmsd_pkg::DEF_REFRESH_CYCLES;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 20;

	class chunk_scoreboard;
		typedef struct {
			logic [lmsd_pkg::PANEL_W-1:0] panel;
			logic [lmsd_pkg::COLOR_W-1:0] color;
			logic [lmsd_pkg::ROW_W-1:0]   row;
			logic [lmsd_pkg::LED_W-1:0]   bits;
			logic                         last;
		} chunk_t;

		logic [lmsd_pkg::WORD_W-1:0] frame [2][PANELS][ROWS][COLORS];
		int unsigned scan_row;
		int unsigned refresh;
		bit shown;
		bit swap_pending;
		lmsd_pkg::sched_t sched [lmsd_pkg::LEVELS];
		chunk_t expected_chunks [$];
		int fails;
		int reported;

		function new();
			foreach (frame[b, p, r, c])
				frame[b][p][r][c] = '0;
			scan_row = 0;
			refresh = 0;
			shown = 1'b1;
			swap_pending = 1'b0;
			sched[0] = lmsd_pkg::SCHED_RST_L0;
			sched[1] = lmsd_pkg::SCHED_RST_L1;
			sched[2] = lmsd_pkg::SCHED_RST_L2;
			sched[3] = lmsd_pkg::SCHED_RST_L3;
			fails = 0;
			reported = 0;
		endfunction

		function void set_schedule(int idx, lmsd_pkg::sched_t value);
			sched[idx] = value;
		endfunction

		function int outstanding();
			return expected_chunks.size();
		endfunction

		function void note_command(lmsd_pkg::cmd_t cmd, bit hidden,
				logic [lmsd_pkg::PANEL_W-1:0] panel, logic [lmsd_pkg::ROW_W-1:0] row_s,
				logic [lmsd_pkg::COLOR_W-1:0] color, logic [lmsd_pkg::WORD_W-1:0] word);
			logic [lmsd_pkg::WORD_W-1:0] levels;
			logic [lmsd_pkg::LED_W-1:0] bits;
			logic [1:0] lvl;
			chunk_t ch;
			case (cmd)
				lmsd_pkg::CMD_WRITE: begin
					if (panel < PANELS && row_s < ROWS && color < COLORS)
						frame[shown ^ hidden][panel][row_s][color] = word;
				end
				lmsd_pkg::CMD_SWAP_DEFER: begin
					swap_pending = 1'b1;
				end
				lmsd_pkg::CMD_SWAP_NOW: begin
					shown = ~shown;
				end
				default: begin
					scan_row++;
					if (scan_row >= ROWS) begin
						scan_row = 0;
						refresh++;
						if (refresh >= CYCLES) begin
							refresh = 0;
							if (swap_pending) begin
								shown = ~shown;
								swap_pending = 1'b0;
							end
						end
					end
					for (int p = 0; p < PANELS; p++) begin
						for (int c = 0; c < COLORS; c++) begin
							levels = frame[shown][p][scan_row][c];
							bits = '0;
							for (int k = 0; k < LEDS && k < lmsd_pkg::LED_W; k++) begin
								lvl = levels[2*k +: 2];
								bits[k] = (refresh < lmsd_pkg::SCHED_W) ?
									sched[lvl][refresh] : 1'b0;
							end
							ch.panel = lmsd_pkg::PANEL_W'(p);
							ch.color = lmsd_pkg::COLOR_W'(c);
							ch.row = lmsd_pkg::ROW_W'(scan_row);
							ch.bits = bits;
							ch.last = (p == PANELS - 1 && c == COLORS - 1);
							expected_chunks.push_back(ch);
						end
					end
				end
			endcase
		endfunction

		function void check_chunk(logic [lmsd_pkg::M_TDATA_W-1:0] tdata,
				logic [lmsd_pkg::M_TUSER_W-1:0] tuser, logic tlast);
			chunk_t got;
			chunk_t exp;
			got.row = tdata[lmsd_pkg::ROW_W-1:0];
			got.bits = tdata[lmsd_pkg::ROW_W +: lmsd_pkg::LED_W];
			got.panel = tuser[lmsd_pkg::PANEL_W-1:0];
			got.color = tuser[lmsd_pkg::PANEL_W +: lmsd_pkg::COLOR_W];
			got.last = tlast;
			if (expected_chunks.size() == 0) begin
				fails++;
				if (reported < 10) begin
					reported++;
					$display("unexpected chunk: panel %0d color %0d row %0d bits %h last %b",
						got.panel, got.color, got.row, got.bits, got.last);
				end
				return;
			end
			exp = expected_chunks.pop_front();
			if (got.panel !== exp.panel || got.color !== exp.color || got.row !== exp.row ||
					got.bits !== exp.bits || got.last !== exp.last) begin
				fails++;
				if (reported < 10) begin
					reported++;
					$display("chunk mismatch: expected panel %0d color %0d row %0d bits %h last %b",
						exp.panel, exp.color, exp.row, exp.bits, exp.last);
					$display("                actual   panel %0d color %0d row %0d bits %h last %b",
						got.panel, got.color, got.row, got.bits, got.last);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [lmsd_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic [lmsd_pkg::S_TUSER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [lmsd_pkg::M_TDATA_W-1:0] m_tdata;
	logic [lmsd_pkg::M_TUSER_W-1:0] m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [lmsd_pkg::REG_W-1:0] cfg_index = '0;
	logic [lmsd_pkg::SCHED_W-1:0] cfg_data = '0;

	bit quiet = 1'b0;
	bit hold_req = 1'b0;
	int stall_cycles = 0;
	chunk_scoreboard sb;

	led_matrix_scan_dimmer_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_cmd(lmsd_pkg::cmd_t cmd, bit hidden,
			logic [lmsd_pkg::PANEL_W-1:0] panel, logic [lmsd_pkg::ROW_W-1:0] row_s,
			logic [lmsd_pkg::COLOR_W-1:0] color, logic [lmsd_pkg::WORD_W-1:0] word);
		if (!quiet && $urandom_range(99) < 9) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {7'd0, word, color, row_s, panel, hidden};
		do @(posedge clk); while (!s_tready);
		sb.note_command(cmd, hidden, panel, row_s, color, word);
	endtask

	task automatic send_any(lmsd_pkg::cmd_t cmd);
		send_cmd(cmd, 1'($urandom_range(1)), lmsd_pkg::PANEL_W'($urandom_range(7)),
			lmsd_pkg::ROW_W'($urandom_range(7)), lmsd_pkg::COLOR_W'($urandom_range(3)),
			lmsd_pkg::WORD_W'($urandom()));
	endtask

	task automatic send_random(int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 55)
				send_any(lmsd_pkg::CMD_TICK);
			else if (r < 90) begin
				if ($urandom_range(9) == 0)
					send_any(lmsd_pkg::CMD_WRITE);
				else
					send_cmd(lmsd_pkg::CMD_WRITE, 1'($urandom_range(1)),
						lmsd_pkg::PANEL_W'($urandom_range(PANELS - 1)),
						lmsd_pkg::ROW_W'($urandom_range(ROWS - 1)),
						lmsd_pkg::COLOR_W'($urandom_range(COLORS - 1)),
						lmsd_pkg::WORD_W'($urandom()));
			end else if (r < 95)
				send_any(lmsd_pkg::CMD_SWAP_DEFER);
			else
				send_any(lmsd_pkg::CMD_SWAP_NOW);
		end
	endtask

	task automatic load_schedules(lmsd_pkg::sched_t vals [lmsd_pkg::LEVELS]);
		for (int i = 0; i < lmsd_pkg::LEVELS; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= lmsd_pkg::reg_idx_t'(i);
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			sb.set_schedule(i, vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.outstanding() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// receiver side: random stalls, quiet stretches and one long hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else
				m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 9);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_chunk(m_tdata, m_tuser, m_tlast);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		lmsd_pkg::sched_t vals [lmsd_pkg::LEVELS];
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset schedules, mixed levels, both buffers, ignored writes
		send_cmd(lmsd_pkg::CMD_TICK, 1'b0, 3'd0, 3'd0, 2'd0, 16'h0000);
		send_cmd(lmsd_pkg::CMD_WRITE, 1'b0, 3'd0, 3'd2, 2'd0, 16'hffff);
		send_cmd(lmsd_pkg::CMD_WRITE, 1'b0, 3'd4, 3'd2, 2'd2, 16'he4e4);
		send_cmd(lmsd_pkg::CMD_WRITE, 1'b1, 3'd0, 3'd4, 2'd1, 16'h5555);
		send_cmd(lmsd_pkg::CMD_WRITE, 1'b0, 3'd2, 3'd2, 2'd1, 16'h1b1b);
		send_cmd(lmsd_pkg::CMD_TICK, 1'b1, 3'd7, 3'd7, 2'd3, 16'hffff);
		send_cmd(lmsd_pkg::CMD_WRITE, 1'b0, 3'd5, 3'd3, 2'd0, 16'hffff);
		send_cmd(lmsd_pkg::CMD_WRITE, 1'b1, 3'd7, 3'd7, 2'd3, 16'hffff);
		send_cmd(lmsd_pkg::CMD_WRITE, 1'b0, 3'd0, 3'd3, 2'd3, 16'hffff);
		send_cmd(lmsd_pkg::CMD_WRITE, 1'b0, 3'd4, 3'd7, 2'd2, 16'hffff);
		send_cmd(lmsd_pkg::CMD_TICK, 1'b0, 3'd0, 3'd0, 2'd0, 16'h0000);
		send_cmd(lmsd_pkg::CMD_SWAP_NOW, 1'b0, 3'd0, 3'd0, 2'd0, 16'h0000);
		send_cmd(lmsd_pkg::CMD_TICK, 1'b0, 3'd0, 3'd0, 2'd0, 16'h0000);
		send_cmd(lmsd_pkg::CMD_SWAP_NOW, 1'b1, 3'd7, 3'd7, 2'd3, 16'hffff);
		send_cmd(lmsd_pkg::CMD_SWAP_DEFER, 1'b0, 3'd0, 3'd0, 2'd0, 16'h0000);
		send_cmd(lmsd_pkg::CMD_SWAP_DEFER, 1'b1, 3'd7, 3'd7, 2'd3, 16'hffff);
		send_cmd(lmsd_pkg::CMD_WRITE, 1'b0, 3'd1, 3'd5, 2'd0, 16'haaaa);
		send_cmd(lmsd_pkg::CMD_WRITE, 1'b1, 3'd1, 3'd0, 2'd0, 16'hffff);
		send_cmd(lmsd_pkg::CMD_WRITE, 1'b0, 3'd3, 3'd0, 2'd2, 16'h0000);
		send_cmd(lmsd_pkg::CMD_TICK, 1'b0, 3'd0, 3'd0, 2'd0, 16'h0000);
		send_cmd(lmsd_pkg::CMD_TICK, 1'b0, 3'd0, 3'd0, 2'd0, 16'h0000);
		send_cmd(lmsd_pkg::CMD_TICK, 1'b0, 3'd0, 3'd0, 2'd0, 16'h0000);
		send_cmd(lmsd_pkg::CMD_TICK, 1'b0, 3'd0, 3'd0, 2'd0, 16'h0000);
		drain();

		for (int phase = 1; phase <= 4; phase++) begin
			for (int i = 0; i < lmsd_pkg::LEVELS; i++) begin
				case (phase)
					1: vals[i] = 6'h3f;
					2: vals[i] = 6'h00;
					default: vals[i] = lmsd_pkg::SCHED_W'($urandom_range(63));
				endcase
			end
			load_schedules(vals);
			quiet = (phase == 2);
			if (phase == 3)
				hold_req = 1'b1;
			send_random(65);
			drain();
			quiet = 1'b0;
		end

		if (sb.fails == 0 && sb.outstanding() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== led_matrix_scan_dimmer_unit.f =====
sv/lmsd_pkg.sv
sv/lmsd_ram.sv
sv/led_matrix_scan_dimmer_unit.sv
test/testbench.sv
